// File: rtl/core/ipcm_pkg.sv
`default_nettype none

package ipcm_pkg;

    localparam int MZ_W        = 32;
    localparam int INTENSITY_W = 32;
    localparam int CHARGE_W    = 7;
    localparam int TOL_W       = 32;
    localparam int ISO_W       = 8;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;

    localparam logic [ISO_W-1:0] ISO_MAX        = '1;
    localparam logic [MZ_W-1:0]  MZ_SATURATED   = '1;
    localparam logic [TOL_W-1:0] TOLERANCE_INIT = 32'd42950;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_TARGET_MZ = 2'd0,
        CFG_CHARGE    = 2'd1,
        CFG_TOLERANCE = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [MZ_W-1:0]  expected_mz;
        logic [ISO_W-1:0] match_count;
        logic             stopped;
    } chain_state_t;

    typedef struct packed {
        logic                   matched;
        logic [MZ_W-1:0]        mz;
        logic [INTENSITY_W-1:0] intensity;
        logic [ISO_W-1:0]       isotope_number;
        logic                   search_stopped;
        logic                   spectrum_end;
    } match_result_t;

endpackage

`default_nettype wire

// File: rtl/core/isotope_peak_chain_matcher.sv
// Pipeline: an accepted peak is registered in the input stage and its result in the
// result register; a result-side stall holds the peak in the input stage.
// Throughput: one peak per cycle; the chain state loop (tolerance multiply, window
// compare, spacing add) is combinational, so peaks only wait while results stall.
// Reset: asynchronous, active low; valid, configuration and chain state registers
// reset, the chain state reloads from target_mz, both pipeline stages come up empty.
`default_nettype none

module isotope_peak_chain_matcher
    import ipcm_pkg::*;
#(
    parameter int MAX_CHARGE   = 64,
    parameter int MZ_FRAC_BITS = 20
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,

    input  wire logic                    cfg_write,
    input  wire logic [CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0]   cfg_data,

    input  wire logic                    in_valid,
    output logic                         in_stall,
    input  wire logic [MZ_W-1:0]         peak_mz,
    input  wire logic [INTENSITY_W-1:0]  peak_intensity,
    input  wire logic                    last_peak,

    output logic                         out_valid,
    input  wire logic                    out_stall,
    output logic                         matched,
    output logic [MZ_W-1:0]              matched_mz,
    output logic [INTENSITY_W-1:0]       matched_intensity,
    output logic [ISO_W-1:0]             isotope_number,
    output logic                         search_stopped,
    output logic                         spectrum_end
);

    localparam logic [MZ_W:0] ONE_MZ = (MZ_W + 1)'(1) << MZ_FRAC_BITS;

    // Configuration and values derived from it at write time.
    logic [MZ_W-1:0]  target_mz_reg;
    logic [TOL_W-1:0] tolerance_reg;
    logic [MZ_W-1:0]  spacing_reg;
    logic [MZ_W:0]    stop_mz_reg;
    logic [MZ_W-1:0]  spacing_lookup;
    logic             cfg_known;

    chain_state_t     state_reg;
    chain_state_t     state_next;

    logic                   s1_valid_reg;
    logic                   s1_valid_next;
    logic [MZ_W-1:0]        s1_mz_reg;
    logic [INTENSITY_W-1:0] s1_intensity_reg;
    logic                   s1_last_reg;

    logic                   out_valid_reg;
    logic                   out_valid_next;
    match_result_t          out_result_reg;
    match_result_t          result;

    logic                   s1_move;
    logic                   in_take;

    ipcm_spacing_rom #(
        .MAX_CHARGE   (MAX_CHARGE),
        .MZ_FRAC_BITS (MZ_FRAC_BITS)
    ) u_spacing_rom (
        .charge  (cfg_data[CHARGE_W-1:0]),
        .spacing (spacing_lookup)
    );

    ipcm_match u_match (
        .state          (state_reg),
        .target_mz      (target_mz_reg),
        .tolerance_frac (tolerance_reg),
        .stop_mz        (stop_mz_reg),
        .spacing        (spacing_reg),
        .peak_mz        (s1_mz_reg),
        .peak_intensity (s1_intensity_reg),
        .last_peak      (s1_last_reg),
        .result         (result),
        .state_next     (state_next)
    );

    always_comb
    begin
        case (cfg_index)
            CFG_TARGET_MZ: cfg_known = 1'b1;
            CFG_CHARGE:    cfg_known = 1'b1;
            CFG_TOLERANCE: cfg_known = 1'b1;
            default:       cfg_known = 1'b0;
        endcase
    end

    // The result register frees up whenever its transaction is taken, so the
    // input stage moves forward in the same cycle.
    assign s1_move  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !s1_move;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_take)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_move)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (s1_move)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_mz_reg         <= '0;
            tolerance_reg         <= TOLERANCE_INIT;
            spacing_reg           <= MZ_W'(ONE_MZ);
            stop_mz_reg           <= ONE_MZ;
            state_reg.expected_mz <= '0;
            state_reg.match_count <= '0;
            state_reg.stopped     <= 1'b0;
            s1_valid_reg          <= 1'b0;
            out_valid_reg         <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write && cfg_known)
            begin
                state_reg.expected_mz <= target_mz_reg;
                state_reg.match_count <= '0;
                state_reg.stopped     <= 1'b0;
                case (cfg_index)
                    CFG_TARGET_MZ:
                    begin
                        target_mz_reg         <= cfg_data[MZ_W-1:0];
                        stop_mz_reg           <= {1'b0, cfg_data[MZ_W-1:0]} + ONE_MZ;
                        state_reg.expected_mz <= cfg_data[MZ_W-1:0];
                    end
                    CFG_CHARGE:
                    begin
                        spacing_reg <= spacing_lookup;
                    end
                    CFG_TOLERANCE:
                    begin
                        tolerance_reg <= cfg_data[TOL_W-1:0];
                    end
                    default:
                    begin
                        tolerance_reg <= tolerance_reg;
                    end
                endcase
            end
            else if (s1_move)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_mz_reg        <= peak_mz;
            s1_intensity_reg <= peak_intensity;
            s1_last_reg      <= last_peak;
        end
        if (s1_move)
        begin
            out_result_reg <= result;
        end
    end

    assign out_valid         = out_valid_reg;
    assign matched           = out_result_reg.matched;
    assign matched_mz        = out_result_reg.mz;
    assign matched_intensity = out_result_reg.intensity;
    assign isotope_number    = out_result_reg.isotope_number;
    assign search_stopped    = out_result_reg.search_stopped;
    assign spectrum_end      = out_result_reg.spectrum_end;

    // A peak that joins the chain can never be the one that stops the search.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && matched |-> !search_stopped)
        else $error("matched result reports a stopped search");

    // Fields of an unmatched peak are zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !matched |-> (isotope_number == '0) && (matched_mz == '0)
                                  && (matched_intensity == '0))
        else $error("unmatched result carries nonzero payload");

    // A register write to a known index restarts the chain.
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_write && cfg_known |=> (state_reg.match_count == '0) && !state_reg.stopped)
        else $error("chain state not reloaded after configuration write");

    // After a spectrum's last peak moves through, the chain is back at its start.
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_move && s1_last_reg |=> (state_reg.expected_mz == target_mz_reg)
                                   && (state_reg.match_count == '0))
        else $error("chain state not reloaded after last peak");

endmodule

`default_nettype wire

// File: rtl/core/ipcm_spacing_rom.sv
`default_nettype none

module ipcm_spacing_rom
    import ipcm_pkg::*;
#(
    parameter int MAX_CHARGE   = 64,
    parameter int MZ_FRAC_BITS = 20
)
(
    input  wire logic [CHARGE_W-1:0] charge,
    output logic      [MZ_W-1:0]     spacing
);

    localparam int IDX_W = (MAX_CHARGE < 2) ? 1 : $clog2(MAX_CHARGE + 1);
    localparam logic [63:0] ONE = 64'(1) << MZ_FRAC_BITS;

    logic [MZ_W-1:0]  rom [MAX_CHARGE + 1];
    logic [IDX_W-1:0] idx;

    // Entry c holds 1/c in the m/z format, rounded to nearest; entry zero holds one.
    for (genvar g = 0; g <= MAX_CHARGE; g++) begin : g_rom
        if (g == 0) begin : g_zero
            assign rom[g] = MZ_W'(ONE);
        end
        else begin : g_entry
            localparam logic [63:0] STEP = (ONE + 64'(g / 2)) / 64'(g);
            assign rom[g] = MZ_W'(STEP);
        end
    end

    // A charge of zero counts as one; charges above the table saturate.
    always_comb
    begin
        if (charge == '0)
        begin
            idx = IDX_W'(1);
        end
        else if (32'(charge) > MAX_CHARGE)
        begin
            idx = IDX_W'(MAX_CHARGE);
        end
        else
        begin
            idx = IDX_W'(charge);
        end
    end

    assign spacing = rom[idx];

endmodule

`default_nettype wire

// File: rtl/core/ipcm_match.sv
`default_nettype none

module ipcm_match
    import ipcm_pkg::*;
(
    input  wire chain_state_t            state,
    input  wire logic [MZ_W-1:0]         target_mz,
    input  wire logic [TOL_W-1:0]        tolerance_frac,
    input  wire logic [MZ_W:0]           stop_mz,
    input  wire logic [MZ_W-1:0]         spacing,
    input  wire logic [MZ_W-1:0]         peak_mz,
    input  wire logic [INTENSITY_W-1:0]  peak_intensity,
    input  wire logic                    last_peak,
    output match_result_t                result,
    output chain_state_t                 state_next
);

    logic [MZ_W+TOL_W-1:0] product;
    logic [MZ_W-1:0]       tol;
    logic [MZ_W-1:0]       low;
    logic [MZ_W:0]         high;
    logic [MZ_W:0]         advanced;
    logic                  hit;
    logic                  stop_now;

    always_comb
    begin
        product  = (MZ_W + TOL_W)'(state.expected_mz) * (MZ_W + TOL_W)'(tolerance_frac);
        tol      = product[MZ_W+TOL_W-1:TOL_W];
        low      = (tol > state.expected_mz) ? '0 : state.expected_mz - tol;
        high     = {1'b0, state.expected_mz} + {1'b0, tol};
        hit      = !state.stopped && (peak_mz >= low) && ({1'b0, peak_mz} <= high);
        stop_now = !state.stopped && ({1'b0, peak_mz} > high) && ({1'b0, peak_mz} > stop_mz);
        advanced = {1'b0, state.expected_mz} + {1'b0, spacing};

        result.matched        = hit;
        result.mz             = hit ? peak_mz : '0;
        result.intensity      = hit ? peak_intensity : '0;
        result.isotope_number = hit ? state.match_count : '0;
        result.search_stopped = state.stopped || stop_now;
        result.spectrum_end   = last_peak;

        state_next = state;
        if (last_peak)
        begin
            state_next.expected_mz = target_mz;
            state_next.match_count = '0;
            state_next.stopped     = 1'b0;
        end
        else if (hit)
        begin
            state_next.expected_mz = advanced[MZ_W] ? MZ_SATURATED : advanced[MZ_W-1:0];
            if (state.match_count != ISO_MAX)
            begin
                state_next.match_count = state.match_count + ISO_W'(1);
            end
        end
        else if (stop_now)
        begin
            state_next.stopped = 1'b1;
        end
    end

endmodule

`default_nettype wire

// File: test/tb_isotope_peak_chain_matcher.sv
`timescale 1ns / 100ps

module tb_isotope_peak_chain_matcher;
    import ipcm_pkg::*;

    localparam int CHARGE_LIMIT = 64;
    localparam int FRAC_BITS    = 20;
    localparam int RANDOM_PEAKS = 1100;
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_INDEX = 2'd3;

    // Predicts the chain matcher result for each accepted peak and checks results in order.
    class chain_scoreboard;
        logic [MZ_W-1:0]     target_mz_r;
        logic [CHARGE_W-1:0] charge_r;
        logic [TOL_W-1:0]    tol_frac_r;
        logic [MZ_W-1:0]     expected_mz;
        logic [ISO_W-1:0]    match_count;
        logic                stopped;
        logic [MZ_W-1:0]     spacing [0:CHARGE_LIMIT];
        match_result_t       pending_results [$];
        int                  errors;

        function new();
            logic [63:0] one;
            one = 64'd1 << FRAC_BITS;
            spacing[0] = one[31:0];
            for (int c = 1; c <= CHARGE_LIMIT; c++)
            begin
                spacing[c] = 32'((one + 64'(c / 2)) / 64'(c));
            end
            target_mz_r = '0;
            charge_r    = 7'd1;
            tol_frac_r  = TOLERANCE_INIT;
            errors      = 0;
            reload();
        endfunction

        function void reload();
            expected_mz = target_mz_r;
            match_count = '0;
            stopped     = 1'b0;
        endfunction

        function void apply_config(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_TARGET_MZ: target_mz_r = data;
                CFG_CHARGE:    charge_r = data[CHARGE_W-1:0];
                CFG_TOLERANCE: tol_frac_r = data;
                default:       return;
            endcase
            reload();
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        function void predict_peak(logic [MZ_W-1:0] mz, logic [INTENSITY_W-1:0] inten,
                                   logic last);
            logic [63:0]         exp64;
            logic [63:0]         tol;
            logic [63:0]         low;
            logic [63:0]         high;
            logic [63:0]         stop_at;
            logic [63:0]         next;
            logic [CHARGE_W-1:0] c;
            match_result_t       r;
            r = '0;
            if (!stopped)
            begin
                exp64   = {32'd0, expected_mz};
                tol     = (exp64 * {32'd0, tol_frac_r}) >> 32;
                low     = (tol > exp64) ? 64'd0 : exp64 - tol;
                high    = exp64 + tol;
                stop_at = {32'd0, target_mz_r} + (64'd1 << FRAC_BITS);
                if ({32'd0, mz} >= low)
                begin
                    if ({32'd0, mz} <= high)
                    begin
                        r.matched        = 1'b1;
                        r.mz             = mz;
                        r.intensity      = inten;
                        r.isotope_number = match_count;
                        if (match_count != ISO_MAX)
                            match_count = match_count + 1'b1;
                        c = charge_r;
                        if (c == 0)
                            c = 7'd1;
                        if (c > CHARGE_LIMIT)
                            c = 7'(CHARGE_LIMIT);
                        next = exp64 + {32'd0, spacing[c]};
                        expected_mz = (next > 64'hFFFF_FFFF) ? MZ_SATURATED : next[31:0];
                    end
                    else if ({32'd0, mz} > stop_at)
                    begin
                        stopped = 1'b1;
                    end
                end
            end
            r.search_stopped = stopped;
            r.spectrum_end   = last;
            pending_results = {pending_results, r};
            if (last)
                reload();
        endfunction

        task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
            $display("%0t MISMATCH %s: got %0h, expected %0h", $time, what, got, want);
            errors++;
        endtask

        task check_result(logic m, logic [MZ_W-1:0] mz, logic [INTENSITY_W-1:0] inten,
                          logic [ISO_W-1:0] iso, logic st, logic se);
            match_result_t want;
            if (pending_results.size() == 0)
            begin
                report_mismatch("result with no pending peak", {63'd0, m}, 64'd0);
                return;
            end
            want = pending_results.pop_front();
            if (m !== want.matched)
                report_mismatch("matched", {63'd0, m}, {63'd0, want.matched});
            if (mz !== want.mz)
                report_mismatch("matched_mz", {32'd0, mz}, {32'd0, want.mz});
            if (inten !== want.intensity)
                report_mismatch("matched_intensity", {32'd0, inten}, {32'd0, want.intensity});
            if (iso !== want.isotope_number)
                report_mismatch("isotope_number", {56'd0, iso}, {56'd0, want.isotope_number});
            if (st !== want.search_stopped)
                report_mismatch("search_stopped", {63'd0, st}, {63'd0, want.search_stopped});
            if (se !== want.spectrum_end)
                report_mismatch("spectrum_end", {63'd0, se}, {63'd0, want.spectrum_end});
        endtask
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   in_valid;
    logic                   in_stall;
    logic [MZ_W-1:0]        peak_mz;
    logic [INTENSITY_W-1:0] peak_intensity;
    logic                   last_peak;
    logic                   out_valid;
    logic                   out_stall;
    logic                   matched;
    logic [MZ_W-1:0]        matched_mz;
    logic [INTENSITY_W-1:0] matched_intensity;
    logic [ISO_W-1:0]       isotope_number;
    logic                   search_stopped;
    logic                   spectrum_end;

    chain_scoreboard sb;
    logic            in_burst;
    logic            out_burst;
    int              random_count;

    isotope_peak_chain_matcher u_top (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_write         (cfg_write),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .peak_mz           (peak_mz),
        .peak_intensity    (peak_intensity),
        .last_peak         (last_peak),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .matched           (matched),
        .matched_mz        (matched_mz),
        .matched_intensity (matched_intensity),
        .isotope_number    (isotope_number),
        .search_stopped    (search_stopped),
        .spectrum_end      (spectrum_end)
    );

    always #5 clk = ~clk;

    // Called at a falling edge; returns at the falling edge after the transaction is accepted.
    task automatic send_peak(input logic [MZ_W-1:0] mz, input logic [INTENSITY_W-1:0] inten,
                             input logic last);
        int gap;
        gap = in_burst ? 0 : $urandom_range(0, 8);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid       <= 1'b1;
        peak_mz        <= mz;
        peak_intensity <= inten;
        last_peak      <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.predict_peak(mz, inten, last);
        @(negedge clk);
    endtask

    // Drops valid so the held transaction is not taken again, then waits out every result.
    task automatic drain_results(input int settle);
        if (in_valid)
            in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (settle) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        sb.apply_config(idx, data);
        @(negedge clk);
        cfg_write <= 1'b0;
        @(negedge clk);
    endtask

    // Chooses a peak m/z relative to the predicted chain window so most spectra go deep.
    function automatic logic [MZ_W-1:0] pick_peak_mz();
        logic [63:0] exp64;
        logic [63:0] tol;
        logic [63:0] low;
        logic [63:0] high;
        logic [63:0] stop_at;
        logic [63:0] pick;
        int          kind;
        exp64   = {32'd0, sb.expected_mz};
        tol     = (exp64 * {32'd0, sb.tol_frac_r}) >> 32;
        low     = (tol > exp64) ? 64'd0 : exp64 - tol;
        high    = exp64 + tol;
        stop_at = {32'd0, sb.target_mz_r} + (64'd1 << FRAC_BITS);
        kind    = $urandom_range(0, 99);
        if (kind < 45)
            pick = low + ({32'd0, $urandom} % (high - low + 64'd1));
        else if (kind < 60)
            pick = (low == 0) ? 64'd0
                 : low - 64'd1 - ({32'd0, $urandom} % ((low < 64'd4096) ? low : 64'd4096));
        else if (kind < 75 && high < stop_at)
            pick = high + 64'd1 + ({32'd0, $urandom} % (stop_at - high));
        else if (kind < 88)
            pick = stop_at + 64'd1 + {32'd0, 32'($urandom_range(0, 32'h3FFFF))};
        else
            pick = {32'd0, $urandom};
        return (pick > 64'hFFFF_FFFF) ? MZ_SATURATED : pick[31:0];
    endfunction

    task automatic random_config();
        int          r;
        logic        any;
        logic [31:0] val;
        any = 1'b0;
        if ($urandom_range(0, 2) != 0)
        begin
            r = $urandom_range(0, 9);
            if (r == 0)
                val = '0;
            else if (r == 1)
                val = '1;
            else if (r == 2)
                val = $urandom;
            else
                val = (32'($urandom_range(50, 3000)) << FRAC_BITS)
                    | 32'($urandom_range(0, 32'hFFFFF));
            write_reg(CFG_TARGET_MZ, val);
            any = 1'b1;
        end
        if ($urandom_range(0, 2) != 0)
        begin
            r = $urandom_range(0, 9);
            if (r == 0)
                val = 32'd0;
            else if (r == 1)
                val = 32'(CHARGE_LIMIT);
            else if (r == 2)
                val = 32'($urandom_range(CHARGE_LIMIT + 1, 127));
            else if (r == 3)
                val = $urandom;
            else
                val = 32'($urandom_range(1, 8));
            write_reg(CFG_CHARGE, val);
            any = 1'b1;
        end
        if (!any || $urandom_range(0, 2) != 0)
        begin
            r = $urandom_range(0, 9);
            if (r == 0)
                val = '0;
            else if (r == 1)
                val = '1;
            else if (r == 2)
                val = $urandom;
            else if (r == 3)
                val = TOLERANCE_INIT;
            else
                val = 32'($urandom_range(4295, 4295 * 50));
            write_reg(CFG_TOLERANCE, val);
        end
        if ($urandom_range(0, 7) == 0)
            write_reg(CFG_UNUSED_INDEX, $urandom);
    endtask

    task automatic random_spectrum();
        int len;
        len = $urandom_range(1, 16);
        in_burst = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 40) == 0)
                drain_results(0);
            send_peak(pick_peak_mz(), $urandom, (i == len - 1));
            random_count++;
        end
    endtask

    // Result side: a random stall before each result, with occasional stall-free stretches.
    initial
    begin
        int n;
        out_stall = 1'b0;
        out_burst = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if ($urandom_range(0, 19) == 0)
                out_burst = ~out_burst;
            n = out_burst ? 0 : $urandom_range(0, 8);
            if (n != 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(negedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            @(negedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(matched, matched_mz, matched_intensity, isotope_number,
                            search_stopped, spectrum_end);
    end

    initial
    begin
        #5_000_000;
        $display("isotope_peak_chain_matcher regression: fail");
        $finish;
    end

    initial
    begin
        logic [MZ_W-1:0] t;
        sb             = new();
        clk            = 1'b0;
        rst_n          = 1'b0;
        cfg_write      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        in_valid       = 1'b0;
        peak_mz        = '0;
        peak_intensity = '0;
        last_peak      = 1'b0;
        in_burst       = 1'b0;
        random_count   = 0;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset settings: a chain starting at zero, then a stop past target plus one.
        send_peak(32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
        send_peak(32'h0010_0000, 32'h0000_0000, 1'b0);
        send_peak(32'h0008_0000, 32'h0000_1234, 1'b0);
        send_peak(32'h0030_0000, 32'h0000_0005, 1'b0);
        send_peak(32'h0020_0000, 32'h0000_0007, 1'b1);

        drain_results(4);
        t = 32'h1F40_0000;
        write_reg(CFG_TARGET_MZ, t);
        write_reg(CFG_CHARGE, 32'd2);
        write_reg(CFG_TOLERANCE, TOLERANCE_INIT);
        send_peak(t - 32'h2000, 32'd1, 1'b0);
        send_peak(t + 32'h1000, 32'd2, 1'b0);
        send_peak(t + 32'h0004_0000, 32'd3, 1'b0);
        send_peak(t + 32'h0008_0000, 32'd4, 1'b0);
        send_peak(t + 32'h0010_0400, 32'd5, 1'b0);
        send_peak(t + 32'h0018_4000, 32'd6, 1'b0);
        send_peak(t + 32'h0018_0000, 32'd7, 1'b1);

        // A write to the unused index must leave the chain where it is.
        send_peak(t, 32'd8, 1'b0);
        drain_results(4);
        write_reg(CFG_UNUSED_INDEX, 32'hFFFF_FFFF);
        send_peak(t + 32'h0008_0000, 32'd9, 1'b1);

        // Expected m/z saturates at the top of the range; charge zero acts as one.
        drain_results(4);
        write_reg(CFG_TARGET_MZ, 32'hFFFF_FFFF);
        write_reg(CFG_CHARGE, 32'd0);
        write_reg(CFG_TOLERANCE, 32'hFFFF_FFFF);
        send_peak(32'h0000_0000, 32'h0000_0000, 1'b0);
        send_peak(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        send_peak(32'hFFFF_FFFF, 32'hA5A5_A5A5, 1'b1);

        // Zero tolerance with an oversized charge, then the largest legal charge.
        drain_results(4);
        write_reg(CFG_TARGET_MZ, 32'h1000_0000);
        write_reg(CFG_CHARGE, 32'd127);
        write_reg(CFG_TOLERANCE, 32'h0000_0000);
        send_peak(32'h1000_0000, 32'd1, 1'b0);
        send_peak(32'h1000_4001, 32'd2, 1'b0);
        send_peak(32'h1000_4000, 32'd3, 1'b1);
        drain_results(4);
        write_reg(CFG_CHARGE, 32'd64);
        send_peak(32'h1000_0000, 32'd4, 1'b0);
        send_peak(32'h1000_4000, 32'h5A5A_5A5A, 1'b1);

        // A long chain at the saturated m/z drives the isotope number into saturation.
        drain_results(4);
        write_reg(CFG_TARGET_MZ, 32'hFFFF_FFFF);
        write_reg(CFG_CHARGE, 32'd3);
        write_reg(CFG_TOLERANCE, 32'h0000_0000);
        in_burst = 1'b1;
        for (int i = 0; i < 300; i++)
        begin
            send_peak(32'hFFFF_FFFF, $urandom, (i == 299));
            random_count++;
        end

        while (random_count < RANDOM_PEAKS)
        begin
            drain_results(4);
            random_config();
            repeat ($urandom_range(2, 6)) random_spectrum();
        end

        drain_results(12);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("isotope_peak_chain_matcher regression: pass");
        else
            $display("isotope_peak_chain_matcher regression: fail");
        $finish;
    end

endmodule
